// ===== hw/rtl/rc6_pkg.sv =====
// shared types, constants and rotate helpers for the rc6 cbc block
package rc6_pkg;

    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;
    localparam logic [4:0]  LGW = 5'd5;
    localparam int          KEY_REGS = 8;
    localparam int          CFG_IW = 4;

    typedef enum logic {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] in_word0;
        logic [31:0] in_word1;
        logic [31:0] in_word2;
        logic [31:0] in_word3;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word0;
        logic [31:0] out_word1;
        logic [31:0] out_word2;
        logic [31:0] out_word3;
    } out_item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

endpackage

// ===== hw/rtl/rc6_rk_ram.sv =====
// round key memory, one write port and two registered read ports
module rc6_rk_ram #(
    parameter int DEPTH = 44,
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [31:0]   rdata0,
    output logic [31:0]   rdata1
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== hw/rtl/rc6_round.sv =====
// one rc6 round, forward or inverse, shared by every round of a block
module rc6_round
    import rc6_pkg::*;
(
    input  logic [3:0][31:0] x,
    input  logic [31:0]      rk0,
    input  logic [31:0]      rk1,
    input  logic             decrypt,
    output logic [3:0][31:0] y
);

    logic [31:0] mb, md, pb, pd, t, u;

    always_comb begin
        // inverse round works on the block rotated right by one word
        mb = decrypt ? x[0] : x[1];
        md = decrypt ? x[2] : x[3];
        pb = mb * {mb[30:0], 1'b1};
        pd = md * {md[30:0], 1'b1};
        t  = rotl(pb, LGW);
        u  = rotl(pd, LGW);
        if (decrypt) begin
            y[0] = rotr(x[3] - rk0, u[4:0]) ^ t;
            y[1] = x[0];
            y[2] = rotr(x[1] - rk1, t[4:0]) ^ u;
            y[3] = x[2];
        end else begin
            y[0] = x[1];
            y[1] = rotl(x[2] ^ u, t[4:0]) + rk1;
            y[2] = x[3];
            y[3] = rotl(x[0] ^ t, u[4:0]) + rk0;
        end
    end

endmodule

// ===== hw/rtl/rc6_cbc_block_cipher.sv =====
// RC6 block cipher in CBC mode: key registers, key schedule and round sequencer.
// One 128-bit block is taken at a time: whitening, one round per cycle, final
// whitening. The next block is taken only once the last block's final whitening
// has written the output register. All rounds share the single round
// unit fed from the two read ports of the round key memory. After
// reset and after every key register write the key schedule loads the key words
// and then runs its mixing steps, one mixing step a cycle; no block and no
// further key write is taken meanwhile. A finished result waits in the output
// register while the next block is processed.
module rc6_cbc_block_cipher
    import rc6_pkg::*;
#(
    parameter int ROUNDS = 20,
    parameter int KEY_WORDS = 16,
    parameter int KEY_BYTES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [63:0]       cfg_data
);

    localparam int NKEYS = 2 * ROUNDS + 4;
    localparam int MIXN = 3 * (KEY_WORDS > NKEYS ? KEY_WORDS : NKEYS);
    localparam int AW = $clog2(NKEYS);
    localparam int JW = $clog2(KEY_WORDS);
    localparam int KW = $clog2(MIXN);
    localparam int RW = $clog2(ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEYS,
        ST_IDLE,
        ST_PRE,
        ST_ROUND,
        ST_POST
    } state_t;

    state_t           state_reg;
    logic [63:0]      key_reg [KEY_REGS];
    logic [31:0]      lw_reg [KEY_WORDS];
    logic [KW-1:0]    ks_k_reg;
    logic [AW-1:0]    ks_i_reg;
    logic [JW-1:0]    ks_j_reg;
    logic [31:0]      a_reg, b_reg, sinit_reg;
    logic [3:0][31:0] enc_chain_reg, dec_chain_reg, x_reg, saved_reg;
    kind_t            kind_reg;
    logic [RW-1:0]    r_reg;
    out_item_t        out_reg;
    logic             m_valid_reg;

    logic [511:0]     key_flat;
    logic [3:0][31:0] chain_init;
    logic [31:0]      lw_init [KEY_WORDS];
    logic [31:0]      s_cur, a_next, b_next, sum_a, sum_b, ab_next;
    logic [AW-1:0]    i_wrap, raddr0, raddr1;
    logic [31:0]      rdata0, rdata1;
    logic [3:0][31:0] round_y, post_y;
    logic             ram_we, cfg_fire, in_fire, post_go;

    always_comb begin
        for (int r = 0; r < KEY_REGS; r++) begin
            key_flat[64*r +: 64] = key_reg[r];
        end
        for (int w = 0; w < KEY_WORDS; w++) begin
            for (int bt = 0; bt < 4; bt++) begin
                lw_init[w][8*bt +: 8] = key_flat[8*((4*w + bt) % KEY_BYTES) +: 8];
            end
        end
        for (int w = 0; w < 4; w++) begin
            chain_init[w] = key_flat[32*w +: 32];
        end
    end

    // key mixing step; the first pass uses the arithmetic series directly
    always_comb begin
        s_cur   = (ks_k_reg < KW'(NKEYS)) ? sinit_reg : rdata0;
        sum_a   = s_cur + a_reg + b_reg;
        a_next  = rotl(sum_a, 5'd3);
        ab_next = a_next + b_reg;
        sum_b   = lw_reg[ks_j_reg] + ab_next;
        b_next  = rotl(sum_b, ab_next[4:0]);
        i_wrap  = (ks_i_reg == AW'(NKEYS - 1)) ? '0 : ks_i_reg + 1'b1;
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_valid && s_ready;
    assign post_go   = !m_valid_reg || m_ready;
    assign ram_we    = (state_reg == ST_KEYS);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // round key addresses are issued in the cycle before their keys are used
    always_comb begin
        raddr0 = '0;
        unique case (state_reg)
            ST_KEYS: raddr0 = i_wrap;
            ST_IDLE: raddr0 = (s_data.kind == KIND_DECRYPT) ? AW'(2 * ROUNDS + 2) : '0;
            ST_PRE:  raddr0 = (kind_reg == KIND_DECRYPT) ? AW'(2 * ROUNDS) : AW'(2);
            ST_ROUND: begin
                if (kind_reg == KIND_DECRYPT) begin
                    raddr0 = AW'({r_reg, 1'b0}) - AW'(2);
                end else begin
                    raddr0 = AW'({r_reg, 1'b0}) + AW'(2);
                end
            end
            ST_POST: raddr0 = (kind_reg == KIND_DECRYPT) ? '0 : AW'(2 * ROUNDS + 2);
            default: raddr0 = '0;
        endcase
        raddr1 = raddr0 + 1'b1;
    end

    rc6_rk_ram #(
        .DEPTH(NKEYS),
        .AW(AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ks_i_reg),
        .wdata (a_next),
        .raddr0(raddr0),
        .raddr1(raddr1),
        .rdata0(rdata0),
        .rdata1(rdata1)
    );

    rc6_round u_round (
        .x      (x_reg),
        .rk0    (rdata0),
        .rk1    (rdata1),
        .decrypt(kind_reg == KIND_DECRYPT),
        .y      (round_y)
    );

    always_comb begin
        post_y = x_reg;
        if (kind_reg == KIND_DECRYPT) begin
            post_y[1] = x_reg[1] - rdata0;
            post_y[3] = x_reg[3] - rdata1;
            post_y    = post_y ^ dec_chain_reg;
        end else begin
            post_y[0] = x_reg[0] + rdata0;
            post_y[2] = x_reg[2] + rdata1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < KEY_REGS; r++) begin
                key_reg[r] <= '0;
            end
        end else begin
            if (state_reg == ST_POST && post_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    for (int w = 0; w < KEY_WORDS; w++) begin
                        lw_reg[w] <= lw_init[w];
                    end
                    enc_chain_reg <= chain_init;
                    dec_chain_reg <= chain_init;
                    ks_k_reg  <= '0;
                    ks_i_reg  <= '0;
                    ks_j_reg  <= '0;
                    a_reg     <= '0;
                    b_reg     <= '0;
                    sinit_reg <= P32;
                    state_reg <= ST_KEYS;
                end
                ST_KEYS: begin
                    a_reg            <= a_next;
                    b_reg            <= b_next;
                    lw_reg[ks_j_reg] <= b_next;
                    sinit_reg        <= sinit_reg + Q32;
                    ks_i_reg         <= i_wrap;
                    ks_j_reg         <= (ks_j_reg == JW'(KEY_WORDS - 1)) ? '0
                                                                         : ks_j_reg + 1'b1;
                    ks_k_reg         <= ks_k_reg + 1'b1;
                    if (ks_k_reg == KW'(MIXN - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cfg_fire) begin
                        // writes beyond the key registers are dropped
                        if (cfg_index < CFG_IW'(KEY_REGS)) begin
                            key_reg[cfg_index[2:0]] <= cfg_data;
                            state_reg <= ST_LOAD;
                        end
                    end else if (in_fire) begin
                        kind_reg  <= s_data.kind;
                        saved_reg <= {s_data.in_word3, s_data.in_word2,
                                      s_data.in_word1, s_data.in_word0};
                        if (s_data.kind == KIND_DECRYPT) begin
                            x_reg <= {s_data.in_word3, s_data.in_word2,
                                      s_data.in_word1, s_data.in_word0};
                        end else begin
                            x_reg <= {s_data.in_word3, s_data.in_word2,
                                      s_data.in_word1, s_data.in_word0} ^ enc_chain_reg;
                        end
                        state_reg <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    if (kind_reg == KIND_DECRYPT) begin
                        x_reg[0] <= x_reg[0] - rdata0;
                        x_reg[2] <= x_reg[2] - rdata1;
                        r_reg    <= RW'(ROUNDS);
                    end else begin
                        x_reg[1] <= x_reg[1] + rdata0;
                        x_reg[3] <= x_reg[3] + rdata1;
                        r_reg    <= RW'(1);
                    end
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    x_reg <= round_y;
                    if (kind_reg == KIND_DECRYPT) begin
                        r_reg <= r_reg - 1'b1;
                        if (r_reg == RW'(1)) begin
                            state_reg <= ST_POST;
                        end
                    end else begin
                        r_reg <= r_reg + 1'b1;
                        if (r_reg == RW'(ROUNDS)) begin
                            state_reg <= ST_POST;
                        end
                    end
                end
                ST_POST: begin
                    // hold here until the output register is free
                    if (post_go) begin
                        out_reg.out_word0 <= post_y[0];
                        out_reg.out_word1 <= post_y[1];
                        out_reg.out_word2 <= post_y[2];
                        out_reg.out_word3 <= post_y[3];
                        if (kind_reg == KIND_DECRYPT) begin
                            dec_chain_reg <= saved_reg;
                        end else begin
                            enc_chain_reg <= post_y;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

// ===== dv/rc6_cbc_checker.sv =====
// block predictor and result checker for the rc6 cbc cipher
`timescale 1ns / 100ps

module rc6_cbc_checker
    import rc6_pkg::*;
#(
    parameter int ROUNDS = 20,
    parameter int KEY_WORDS = 16,
    parameter int KEY_BYTES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [63:0]       cfg_data,
    output int                mismatches,
    output int                outstanding
);

    localparam int NUM_RK = 2 * ROUNDS + 4;
    localparam int MIX_STEPS = 3 * (KEY_WORDS > NUM_RK ? KEY_WORDS : NUM_RK);

    typedef logic [3:0][31:0] block_t;

    logic [63:0] key_bytes [KEY_REGS];
    logic [31:0] sched [NUM_RK];
    block_t      enc_iv;
    block_t      dec_iv;
    out_item_t   expected_blocks[$];

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        return (n == 0) ? x : ((x << n) | (x >> (6'd32 - n)));
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        return (n == 0) ? x : ((x >> n) | (x << (6'd32 - n)));
    endfunction

    function automatic logic [7:0] kbyte(input int n);
        int idx;
        idx = n % KEY_BYTES;
        return key_bytes[idx / 8][8 * (idx % 8) +: 8];
    endfunction

    function automatic logic [31:0] kword(input int w);
        return {kbyte(4 * w + 3), kbyte(4 * w + 2), kbyte(4 * w + 1), kbyte(4 * w)};
    endfunction

    // rebuild round keys and both chaining values from the key registers
    task automatic expand_key();
        logic [31:0] lw [KEY_WORDS];
        logic [31:0] a, b;
        int i, j;
        a = 0;
        b = 0;
        i = 0;
        j = 0;
        for (int w = 0; w < 4; w++) begin
            enc_iv[w] = kword(w);
            dec_iv[w] = kword(w);
        end
        for (int w = 0; w < KEY_WORDS; w++) lw[w] = kword(w);
        sched[0] = P32;
        for (int k = 1; k < NUM_RK; k++) sched[k] = sched[k - 1] + Q32;
        for (int k = 0; k < MIX_STEPS; k++) begin
            sched[i] = rol32(sched[i] + a + b, 5'd3);
            a = sched[i];
            lw[j] = rol32(lw[j] + a + b, 5'(a + b));
            b = lw[j];
            i = (i + 1) % NUM_RK;
            j = (j + 1) % KEY_WORDS;
        end
    endtask

    function automatic block_t encipher(input block_t x);
        logic [31:0] t, u, s;
        x[1] += sched[0];
        x[3] += sched[1];
        for (int r = 1; r <= ROUNDS; r++) begin
            t = rol32(x[1] * (2 * x[1] + 1), LGW);
            u = rol32(x[3] * (2 * x[3] + 1), LGW);
            x[0] = rol32(x[0] ^ t, u[4:0]) + sched[2 * r];
            x[2] = rol32(x[2] ^ u, t[4:0]) + sched[2 * r + 1];
            s = x[0]; x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = s;
        end
        x[0] += sched[2 * ROUNDS + 2];
        x[2] += sched[2 * ROUNDS + 3];
        return x;
    endfunction

    function automatic block_t decipher(input block_t x);
        logic [31:0] t, u, s;
        x[0] -= sched[2 * ROUNDS + 2];
        x[2] -= sched[2 * ROUNDS + 3];
        for (int r = ROUNDS; r >= 1; r--) begin
            s = x[3]; x[3] = x[2]; x[2] = x[1]; x[1] = x[0]; x[0] = s;
            t = rol32(x[1] * (2 * x[1] + 1), LGW);
            u = rol32(x[3] * (2 * x[3] + 1), LGW);
            x[0] = ror32(x[0] - sched[2 * r], u[4:0]) ^ t;
            x[2] = ror32(x[2] - sched[2 * r + 1], t[4:0]) ^ u;
        end
        x[1] -= sched[0];
        x[3] -= sched[1];
        return x;
    endfunction

    task automatic cbc_process_block(input in_item_t it);
        block_t x, res;
        out_item_t o;
        x = {it.in_word3, it.in_word2, it.in_word1, it.in_word0};
        if (it.kind == KIND_ENCRYPT) begin
            res = encipher(x ^ enc_iv);
            enc_iv = res;
        end else begin
            res = decipher(x) ^ dec_iv;
            dec_iv = x;
        end
        o.out_word0 = res[0];
        o.out_word1 = res[1];
        o.out_word2 = res[2];
        o.out_word3 = res[3];
        expected_blocks.push_back(o);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch %s", $realtime, msg);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int r = 0; r < KEY_REGS; r++) key_bytes[r] = '0;
            expand_key();
            expected_blocks.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_data.out_word0 !== want.out_word0)
                        report_mismatch($sformatf("out_word0: got %08h expected %08h",
                                                  m_data.out_word0, want.out_word0));
                    if (m_data.out_word1 !== want.out_word1)
                        report_mismatch($sformatf("out_word1: got %08h expected %08h",
                                                  m_data.out_word1, want.out_word1));
                    if (m_data.out_word2 !== want.out_word2)
                        report_mismatch($sformatf("out_word2: got %08h expected %08h",
                                                  m_data.out_word2, want.out_word2));
                    if (m_data.out_word3 !== want.out_word3)
                        report_mismatch($sformatf("out_word3: got %08h expected %08h",
                                                  m_data.out_word3, want.out_word3));
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < KEY_REGS) begin
                key_bytes[cfg_index[2:0]] = cfg_data;
                expand_key();
            end
            if (s_valid && s_ready) cbc_process_block(s_data);
        end
        outstanding <= expected_blocks.size();
    end

endmodule

// ===== dv/testbench.sv =====
// stimulus, handshake pacing and verdict for the rc6 cbc cipher
`timescale 1ns / 100ps

module testbench;
    import rc6_pkg::*;

    localparam int SETTLE = 30;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [CFG_IW-1:0] KEY_IDX_24_31 = CFG_IW'(3);

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [63:0]       cfg_data = '0;
    int                mismatches;
    int                outstanding;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;
    int quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rc6_cbc_block_cipher i_dut (.*);

    rc6_cbc_checker i_checker (.*);

    // receiver pacing, with a long hold-off when one is requested
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            m_ready <= 1'b0;
            rx_hold_req <= rx_hold_req - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rc6_cbc_block_cipher verification failed");
            $finish;
        end
    end

    task automatic send_block(input kind_t kind, input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input logic [31:0] w3);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= '{kind: kind, in_word0: w0, in_word1: w1, in_word2: w2, in_word3: w3};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_block();
        send_block(kind_t'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_key_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_random_key();
        for (int r = 0; r < KEY_REGS; r++) write_key_reg(CFG_IW'(r), {$urandom, $urandom});
    endtask

    task automatic random_phase(input int count, input int idle, input int stall);
        tx_idle_pct = idle;
        rx_stall_pct = stall;
        for (int n = 0; n < count; n++) send_random_block();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero key straight out of reset
        send_block(KIND_ENCRYPT, '0, '0, '0, '0);
        send_block(KIND_ENCRYPT, '1, '1, '1, '1);
        send_block(KIND_DECRYPT, '0, '0, '0, '0);
        send_block(KIND_DECRYPT, '1, '1, '1, '1);
        send_block(KIND_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000);
        drain();

        // all-ones key, then out-of-range indexes that must change nothing
        for (int r = 0; r < KEY_REGS; r++) write_key_reg(CFG_IW'(r), '1);
        write_key_reg(CFG_IW'(KEY_REGS), 64'h0123_4567_89AB_CDEF);
        write_key_reg('1, '0);
        send_block(KIND_ENCRYPT, '0, '0, '0, '0);
        send_block(KIND_ENCRYPT, '1, '1, '1, '1);
        send_block(KIND_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001);
        send_block(KIND_DECRYPT, '1, '0, '1, '0);
        drain();

        // single register changed from a zero key reloads the chains too
        for (int r = 0; r < KEY_REGS; r++) write_key_reg(CFG_IW'(r), '0);
        write_key_reg(KEY_IDX_24_31, 64'h8000_0000_0000_0001);
        for (int n = 0; n < 8; n++) send_random_block();
        drain();

        load_random_key();
        random_phase(110, 0, 0);

        load_random_key();
        tx_idle_pct = 54;
        rx_stall_pct = 0;
        for (int n = 0; n < 50; n++) send_random_block();
        // sender waits for every outstanding result before carrying on
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        for (int n = 0; n < 50; n++) send_random_block();
        drain();

        write_key_reg(CFG_IW'($urandom_range(KEY_REGS - 1)), {$urandom, $urandom});
        write_key_reg(CFG_IW'($urandom_range(15, KEY_REGS)), {$urandom, $urandom});
        tx_idle_pct = 0;
        rx_stall_pct = 54;
        rx_hold_req = 250;
        for (int n = 0; n < 100; n++) send_random_block();
        drain();

        load_random_key();
        random_phase(100, 37, 37);

        if (mismatches == 0)
            $display("rc6_cbc_block_cipher verification clean");
        else
            $display("rc6_cbc_block_cipher verification failed");
        $finish;
    end

endmodule
